// ===== rtl/kss_pkg.sv =====
`default_nettype none

package kss_pkg;

  // Fixed field widths.
  localparam int VALUE_W = 30;
  localparam int RANK_W  = 10;

  // Default capacity of the element store.
  localparam int MAX_ELEMENTS_DEF = 1024;

  // Configuration port geometry.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register index, taken from paddr[2].
  localparam logic REG_RANK = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_MID,
    ST_RD_LAST,
    ST_PIVOT,
    ST_PIV_SWAP,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SWAP_RD,
    ST_SWAP_WR,
    ST_FIN_RD,
    ST_FIN_WR
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/kss_if.sv =====
`default_nettype none

// Input channel: one element word per handshake.
interface kss_in_if import kss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               is_last;

  modport source (output valid, value, is_last, input ready);
  modport sink   (input valid, value, is_last, output ready);
endinterface

// Output channel: one result word per batch.
interface kss_out_if import kss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] selected;
  logic               rank_error;

  modport source (output valid, selected, rank_error, input ready);
  modport sink   (input valid, selected, rank_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/kth_smallest_select_unit.sv =====
`default_nettype none

// Channel   Direction  Payload                        Handshake
// -------   ---------  -----------------------------  -------------------------
// in_i      in         value[29:0], is_last           valid/ready
// out_o     out        selected[29:0], rank_error     valid/ready
// APB       in/out     rank at byte address 0         psel/penable, pready high
//
// Loading accepts one element word per cycle while input is open. A word with is_last starts a quickselect:
// each pass reads the first, middle and last words and picks the pivot, moving it to the end when it lies
// elsewhere, scans each element and swaps one at or below the pivot to the front from behind the boundary,
// and places the pivot at the boundary once the scan reaches the pivot slot.
// A rank at or beyond the count gives an error word on the next cycle. Reset clears control only.
// Every input word waits during selection and while an earlier result word has not been taken.
module kth_smallest_select_unit import kss_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  kss_in_if.sink              in_i,
  kss_out_if.source           out_o,
  input  wire                 psel_i,
  input  wire                 penable_i,
  input  wire                 pwrite_i,
  input  wire [PADDR_W-1:0]   paddr_i,
  input  wire [PDATA_W-1:0]   pwdata_i,
  output logic [PDATA_W-1:0]  prdata_o,
  output logic                pready_o
);

  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  // Element store: one write and one registered read per cycle.
  logic [VALUE_W-1:0] store_q [MAX_ELEMENTS];
  logic [VALUE_W-1:0] rd_data_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [VALUE_W-1:0] wr_data;

  state_e             state_q, state_d;
  logic [RANK_W-1:0]  rank_q, rank_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   range_first_q, range_first_d;
  logic [IDX_W-1:0]   range_final_q, range_final_d;
  logic [IDX_W-1:0]   boundary_q, boundary_d;
  logic [IDX_W-1:0]   scan_q, scan_d;
  logic [IDX_W-1:0]   target_q, target_d;
  logic [IDX_W-1:0]   pivot_idx_q, pivot_idx_d;
  logic [VALUE_W-1:0] pivot_q, pivot_d;
  logic [VALUE_W-1:0] first_val_q, first_val_d;
  logic [VALUE_W-1:0] mid_val_q, mid_val_d;
  logic [VALUE_W-1:0] last_val_q, last_val_d;
  logic [VALUE_W-1:0] hold_q, hold_d;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] selected_q, selected_d;
  logic               rank_error_q, rank_error_d;

  logic               in_ready;
  logic               in_accept;
  logic               cfg_write;
  logic               store_has_room;
  logic [CNT_W-1:0]   count_next;
  logic [CMP_W-1:0]   rank_ext;
  logic [CMP_W-1:0]   count_ext;
  logic [IDX_W:0]     mid_sum;
  logic [IDX_W-1:0]   mid_idx;
  logic [IDX_W-1:0]   span;
  logic               small_range;
  logic               mid_between;
  logic               last_between;
  logic [IDX_W-1:0]   pick_idx;
  logic [VALUE_W-1:0] pick_val;
  logic               scan_le;

  // Configuration port.
  assign pready_o  = 1'b1;
  assign cfg_write = psel_i && penable_i && pwrite_i && pready_o;
  assign prdata_o  = (paddr_i[2] == REG_RANK) ?
                     {{(PDATA_W-RANK_W){1'b0}}, rank_q} : '0;

  always_comb begin
    rank_d = rank_q;
    if (cfg_write && (paddr_i[2] == REG_RANK)) begin
      rank_d = pwdata_i[RANK_W-1:0];
    end
  end

  // Handshakes.
  assign in_ready         = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_i.ready       = in_ready;
  assign in_accept        = in_i.valid && in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.selected   = selected_q;
  assign out_o.rank_error = rank_error_q;

  // Load bookkeeping; the count saturates once the store is full.
  assign store_has_room = (count_q < CNT_W'(MAX_ELEMENTS));
  assign count_next     = store_has_room ? (count_q + CNT_W'(1)) : count_q;
  assign rank_ext       = CMP_W'(rank_q);
  assign count_ext      = CMP_W'(count_next);

  // Range geometry and median-of-three pivot choice.
  assign mid_sum     = {1'b0, range_first_q} + {1'b0, range_final_q} + (IDX_W+1)'(1);
  assign mid_idx     = mid_sum[IDX_W:1];
  assign span        = range_final_q - range_first_q;
  assign small_range = ({1'b0, span} < (IDX_W+1)'(2));

  assign mid_between  = ((mid_val_q >= first_val_q) && (mid_val_q <= rd_data_q)) ||
                        ((mid_val_q >= rd_data_q) && (mid_val_q <= first_val_q));
  assign last_between = ((rd_data_q >= first_val_q) && (rd_data_q <= mid_val_q)) ||
                        ((rd_data_q >= mid_val_q) && (rd_data_q <= first_val_q));

  always_comb begin
    pick_idx = range_first_q;
    pick_val = first_val_q;
    if (!small_range) begin
      if (mid_between) begin
        pick_idx = mid_idx;
        pick_val = mid_val_q;
      end else if (last_between) begin
        pick_idx = range_final_q;
        pick_val = rd_data_q;
      end
    end
  end

  assign scan_le = (rd_data_q <= pivot_q);

  // Next state and datapath registers.
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    range_first_d = range_first_q;
    range_final_d = range_final_q;
    boundary_d    = boundary_q;
    scan_d        = scan_q;
    target_d      = target_q;
    pivot_idx_d   = pivot_idx_q;
    pivot_d       = pivot_q;
    first_val_d   = first_val_q;
    mid_val_d     = mid_val_q;
    last_val_d    = last_val_q;
    hold_d        = hold_q;
    selected_d    = selected_q;
    rank_error_d  = rank_error_q;
    out_valid_d   = out_valid_q && !out_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          count_d = count_next;
          if (in_i.is_last) begin
            count_d = '0;
            if (rank_ext >= count_ext) begin
              selected_d   = '0;
              rank_error_d = 1'b1;
              out_valid_d  = 1'b1;
            end else begin
              target_d      = rank_ext[IDX_W-1:0];
              range_first_d = '0;
              range_final_d = IDX_W'(count_next - CNT_W'(1));
              rank_error_d  = 1'b0;
              state_d       = ST_RD_FIRST;
            end
          end
        end
      end
      ST_RD_FIRST: begin
        state_d = ST_RD_MID;
      end
      ST_RD_MID: begin
        first_val_d = rd_data_q;
        state_d     = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        mid_val_d = rd_data_q;
        state_d   = ST_PIVOT;
      end
      ST_PIVOT: begin
        last_val_d  = rd_data_q;
        pivot_idx_d = pick_idx;
        pivot_d     = pick_val;
        boundary_d  = range_first_q;
        scan_d      = range_first_q;
        state_d     = (pick_idx != range_final_q) ? ST_PIV_SWAP : ST_SCAN_RD;
      end
      ST_PIV_SWAP: begin
        state_d = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        state_d = (scan_q == range_final_q) ? ST_FIN_RD : ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        state_d = ST_SCAN_RD;
        if (scan_le) begin
          if (boundary_q == scan_q) begin
            boundary_d = boundary_q + IDX_W'(1);
            scan_d     = scan_q + IDX_W'(1);
          end else begin
            hold_d  = rd_data_q;
            state_d = ST_SWAP_RD;
          end
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      ST_SWAP_RD: begin
        // The word at the boundary arrives now and goes to the scan slot.
        hold_d  = rd_data_q;
        state_d = ST_SWAP_WR;
      end
      ST_SWAP_WR: begin
        boundary_d = boundary_q + IDX_W'(1);
        scan_d     = scan_q + IDX_W'(1);
        state_d    = ST_SCAN_RD;
      end
      ST_FIN_RD: begin
        state_d = ST_FIN_WR;
      end
      ST_FIN_WR: begin
        if (boundary_q == target_q) begin
          selected_d  = pivot_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else if (boundary_q < target_q) begin
          range_first_d = boundary_q + IDX_W'(1);
          state_d       = ST_RD_FIRST;
        end else begin
          range_final_d = boundary_q - IDX_W'(1);
          state_d       = ST_RD_FIRST;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Store port controls.
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;

    unique case (state_q)
      ST_IDLE: begin
        wr_en   = in_accept && store_has_room;
        wr_addr = count_q[IDX_W-1:0];
        wr_data = in_i.value;
      end
      ST_RD_FIRST: begin
        rd_addr = range_first_q;
      end
      ST_RD_MID: begin
        rd_addr = mid_idx;
      end
      ST_RD_LAST: begin
        rd_addr = range_final_q;
      end
      ST_PIVOT: begin
        // Pivot word moves to the end of the range.
        wr_en   = (pick_idx != range_final_q);
        wr_addr = range_final_q;
        wr_data = pick_val;
      end
      ST_PIV_SWAP: begin
        wr_en   = 1'b1;
        wr_addr = pivot_idx_q;
        wr_data = last_val_q;
      end
      ST_SCAN_RD: begin
        rd_addr = scan_q;
      end
      ST_SCAN_CMP: begin
        rd_addr = boundary_q;
      end
      ST_SWAP_RD: begin
        wr_en   = 1'b1;
        wr_addr = boundary_q;
        wr_data = hold_q;
      end
      ST_SWAP_WR: begin
        wr_en   = 1'b1;
        wr_addr = scan_q;
        wr_data = hold_q;
      end
      ST_FIN_RD: begin
        // Read-before-write returns the old boundary word next cycle.
        rd_addr = boundary_q;
        wr_en   = 1'b1;
        wr_addr = boundary_q;
        wr_data = pivot_q;
      end
      ST_FIN_WR: begin
        wr_en   = 1'b1;
        wr_addr = range_final_q;
        wr_data = rd_data_q;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= store_q[rd_addr];
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      rank_q        <= '0;
      count_q       <= '0;
      range_first_q <= '0;
      range_final_q <= '0;
      boundary_q    <= '0;
      scan_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      rank_q        <= rank_d;
      count_q       <= count_d;
      range_first_q <= range_first_d;
      range_final_q <= range_final_d;
      boundary_q    <= boundary_d;
      scan_q        <= scan_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q     <= target_d;
    pivot_idx_q  <= pivot_idx_d;
    pivot_q      <= pivot_d;
    first_val_q  <= first_val_d;
    mid_val_q    <= mid_val_d;
    last_val_q   <= last_val_d;
    hold_q       <= hold_d;
    selected_q   <= selected_d;
    rank_error_q <= rank_error_d;
  end

endmodule

`default_nettype wire
